>>> hdl/traffic_anomaly_threat_scorer_top_macros.svh
// Assertion macros for the threat scorer.
// Included by the top level; no other dependencies.
`ifndef TRAFFIC_ANOMALY_THREAT_SCORER_TOP_MACROS_SVH
`define TRAFFIC_ANOMALY_THREAT_SCORER_TOP_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define TATS_ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TATS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/tats_pkg.sv
// Shared types, constants and helper functions of the threat scorer.
// No dependencies.
`default_nettype none

package tats_pkg;

   localparam int BASE_DEPTH_DEF  = 20;
   localparam int STORM_DEPTH_DEF = 5;
   localparam int COUNT_BITS      = 16;

   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ACC_W      = 10;
   localparam int OP_W       = 56;
   localparam int SHORT_W    = 32;
   localparam int REM_W      = 30;
   localparam int MEAN_W     = 24;
   localparam int SD_W       = 24;
   localparam int DVS_W      = 24;

   localparam logic [31:0] COUNT_MAX =
      (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNT_BITS) - 32'd1);

   localparam logic [CSR_IDX_W-1:0] REG_PACKET_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BURST_MUL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEAUTH_THR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STORM_MUL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON_THR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PROBE_THR  = 3'd5;

   localparam logic [1:0] STATUS_SAFE   = 2'd0;
   localparam logic [1:0] STATUS_WARN   = 2'd1;
   localparam logic [1:0] STATUS_ATTACK = 2'd2;
   localparam logic [1:0] STATUS_CALIB  = 2'd3;

   localparam logic [1:0] WIN_MGMT   = 2'd0;
   localparam logic [1:0] WIN_DEAUTH = 2'd1;
   localparam logic [1:0] WIN_PROBE  = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] packet_count;
      logic [CNT_W-1:0] mgmt_count;
      logic [CNT_W-1:0] deauth_count;
      logic [CNT_W-1:0] bcast_deauth_count;
      logic [CNT_W-1:0] probe_count;
      logic [CNT_W-1:0] beacon_count;
      logic [CNT_W-1:0] auth_count;
      logic             scanning;
   } req_type;

   typedef struct packed {
      logic [6:0] threat_score;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_MEAN, ST_VAR, ST_VDIV, ST_SQRT, ST_ANOM, ST_ACMP,
      ST_ZDIV, ST_ZTERM, ST_PUSH, ST_HEUR, ST_STORM, ST_SCMP, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
      logic is_long;
   } du_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } du_stat_type;

   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
      return ({16'b0, v} > COUNT_MAX) ? COUNT_MAX[CNT_W-1:0] : v;
   endfunction

   function automatic logic [SD_W-1:0] win_floor(input logic [1:0] w);
      logic [SD_W-1:0] f;
      case (w)
         WIN_MGMT:   f = 24'd512;
         WIN_DEAUTH: f = 24'd256;
         default:    f = 24'd1280;
      endcase
      return f;
   endfunction

   function automatic logic [5:0] z_gain(input logic [1:0] w);
      logic [5:0] g;
      case (w)
         WIN_MGMT:   g = 6'd12;
         WIN_DEAUTH: g = 6'd35;
         default:    g = 6'd10;
      endcase
      return g;
   endfunction

   function automatic logic [5:0] z_cap(input logic [1:0] w);
      logic [5:0] c;
      case (w)
         WIN_DEAUTH: c = 6'd45;
         default:    c = 6'd40;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/tats_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tats_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/tats_divsqrt.sv
// Shared iterative unit: restoring divide (one bit per cycle) or
// integer square root (two bits per cycle). Depends on tats_pkg.
`default_nettype none

module tats_divsqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tats_pkg::du_cmd_type           cmd,
   input  wire logic [tats_pkg::OP_W-1:0]      operand,
   input  wire logic [tats_pkg::DVS_W-1:0]     divisor,
   output tats_pkg::du_stat_type               stat,
   output logic      [tats_pkg::OP_W-1:0]      result
);

   localparam int OP_W  = tats_pkg::OP_W;
   localparam int REM_W = tats_pkg::REM_W;
   localparam int CNTW  = $clog2(OP_W + 1);

   logic [OP_W-1:0]             a_ff, a_in, q_ff, q_in;
   logic [REM_W-1:0]            r_ff, r_in, r_sh, trial;
   logic [tats_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [CNTW-1:0]             cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in, sqrt_ff, sqrt_in;
   logic                        ge;

   always_comb begin
      r_sh  = sqrt_ff ? {r_ff[REM_W-3:0], a_ff[OP_W-1 -: 2]}
                      : {r_ff[REM_W-2:0], a_ff[OP_W-1]};
      trial = sqrt_ff ? {q_ff[REM_W-3:0], 2'b01}
                      : {{(REM_W-tats_pkg::DVS_W){1'b0}}, dvs_ff};
      ge    = (r_sh >= trial);

      a_in    = a_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         a_in    = cmd.is_long ? operand
                               : {operand[tats_pkg::SHORT_W-1:0],
                                  {(OP_W-tats_pkg::SHORT_W){1'b0}}};
         q_in    = '0;
         r_in    = '0;
         dvs_in  = divisor;
         sqrt_in = cmd.is_sqrt;
         busy_in = 1'b1;
         if (cmd.is_long) begin
            cnt_in = cmd.is_sqrt ? CNTW'(OP_W / 2) : CNTW'(OP_W);
         end else begin
            cnt_in = cmd.is_sqrt ? CNTW'(tats_pkg::SHORT_W / 2)
                                 : CNTW'(tats_pkg::SHORT_W);
         end
      end else if (busy_ff) begin
         a_in   = sqrt_ff ? (a_ff << 2) : (a_ff << 1);
         r_in   = ge ? (r_sh - trial) : r_sh;
         q_in   = {q_ff[OP_W-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      dvs_ff  <= dvs_in;
      sqrt_ff <= sqrt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = q_ff;

endmodule

`default_nettype wire

>>> hdl/traffic_anomaly_threat_scorer_top.sv
// Threat scorer top level: sequencer, baselines, heuristics and ports.
// Depends on tats_pkg, tats_ram, tats_divsqrt and the assertion macros.
//
//   channel | ports                           | direction
//   req     | req_valid/req_ready/req_data    | in, one interval of counts
//   rsp     | rsp_valid/rsp_ready/rsp_data    | out, score and status
//   csr     | csr_we/csr_index/csr_wdata      | in, register write
//
// A scanning interval goes straight to the output state; a calibrating
// interval passes through the push state first. A detection interval
// runs through the shared divide/square-root unit (mean, variance, root
// and Z-score per baseline) and through the baseline RAM read passes.
// req_ready is high only in the idle state; a result waits in the output
// register until taken, and the next request is accepted meanwhile.
`default_nettype none
`include "traffic_anomaly_threat_scorer_top_macros.svh"

module traffic_anomaly_threat_scorer_top #(
   parameter int BASE_DEPTH  = tats_pkg::BASE_DEPTH_DEF,
   parameter int STORM_DEPTH = tats_pkg::STORM_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tats_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tats_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [tats_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tats_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W  = tats_pkg::CNT_W;
   localparam int ACC_W  = tats_pkg::ACC_W;
   localparam int MEAN_W = tats_pkg::MEAN_W;
   localparam int SD_W   = tats_pkg::SD_W;
   localparam int OP_W   = tats_pkg::OP_W;
   localparam int FILL_W = $clog2(BASE_DEPTH + 1);
   localparam int AW     = $clog2(BASE_DEPTH);
   localparam int SP_W   = $clog2(STORM_DEPTH);
   localparam int SI_W   = $clog2(STORM_DEPTH + 1);
   localparam int SUM_W  = CNT_W + FILL_W;
   localparam int SQ_W   = 2 * MEAN_W;
   localparam int QS_W   = SQ_W + FILL_W;
   localparam int TOT_W  = CNT_W + SI_W;

   // configuration
   logic [CNT_W-1:0] pkt_thr_ff, pkt_thr_in, bm_ff, bm_in, dthr_ff, dthr_in;
   logic [CNT_W-1:0] bthr_ff, bthr_in, pthr_ff, pthr_in;
   logic [7:0]       smul_ff, smul_in;

   // control and state
   tats_pkg::state_type state_ff, state_in;
   logic [1:0]          win_ff, win_in;
   tats_pkg::req_type   req_ff, req_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [6:0]          score_ff, score_in;
   logic                cal_ff, cal_in;
   logic [FILL_W-1:0]   fill_ff [3];
   logic [FILL_W-1:0]   fill_in [3];
   logic [AW-1:0]       ptr_ff [3];
   logic [AW-1:0]       ptr_in [3];
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic                p1_ff, p1_in, p2_ff, p2_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [QS_W-1:0]     qsum_ff, qsum_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [MEAN_W-1:0]   mean_ff [3];
   logic [MEAN_W-1:0]   mean_in [3];
   logic [SD_W-1:0]     sd_ff, sd_in;
   logic [CNT_W+SD_W-1:0] prod_ff, prod_in;
   logic [23:0]         z_ff, z_in;
   logic [2:0]          anom_ff, anom_in;
   logic [CNT_W-1:0]    storm_ff [STORM_DEPTH];
   logic [CNT_W-1:0]    storm_in [STORM_DEPTH];
   logic [SP_W-1:0]     sptr_ff, sptr_in;
   logic [SI_W-1:0]     sidx_ff, sidx_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tats_pkg::rsp_type   rsp_ff, rsp_in;

   // RAM and shared unit
   logic [2:0]          wr_en;
   logic [CNT_W-1:0]    wr_data [3];
   logic [CNT_W-1:0]    rd_data [3];
   tats_pkg::du_cmd_type  du_cmd;
   tats_pkg::du_stat_type du_stat;
   logic [OP_W-1:0]     du_op, du_res;
   logic [tats_pkg::DVS_W-1:0] du_dvs;

   // scratch
   logic [CNT_W-1:0]    x_cur, rd_sel;
   logic [FILL_W-1:0]   fill_cur;
   logic [MEAN_W-1:0]   mean_cur;
   logic                issue;
   logic [MEAN_W:0]     dvar;
   logic [MEAN_W-1:0]   adev;
   logic [MEAN_W-1:0]   xs, zdiff;
   logic [SD_W-1:0]     root;
   logic [CNT_W+SD_W:0] lhs, rhs;
   logic [23:0]         zd;
   logic [29:0]         zp;
   logic [5:0]          zt;
   logic [2:0]          pushm;
   logic [FILL_W-1:0]   fill_nx [3];
   logic [CNT_W+1:0]    mg_s8, pr_s8;
   logic [MEAN_W+1:0]   mm4, pm4;
   logic [MEAN_W+2:0]   mm5;
   logic [23:0]         limit;
   logic [24:0]         excess;
   logic [6:0]          sat;
   logic [1:0]          stat_code;
   tats_pkg::req_type   req_sat;

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_win
         tats_ram #(.WIDTH(CNT_W), .DEPTH(BASE_DEPTH)) u_ram (
            .clock   (clock),
            .wr_en   (wr_en[k]),
            .wr_addr (ptr_ff[k]),
            .wr_data (wr_data[k]),
            .rd_addr (idx_ff[AW-1:0]),
            .rd_data (rd_data[k])
         );
      end
   endgenerate

   tats_divsqrt u_du (
      .clock   (clock),
      .reset   (reset),
      .cmd     (du_cmd),
      .operand (du_op),
      .divisor (du_dvs),
      .stat    (du_stat),
      .result  (du_res)
   );

   assign wr_data[0] = req_ff.mgmt_count;
   assign wr_data[1] = req_ff.deauth_count;
   assign wr_data[2] = req_ff.probe_count;

   always_comb begin
      req_sat                    = req_data;
      req_sat.packet_count       = tats_pkg::sat_count(req_data.packet_count);
      req_sat.mgmt_count         = tats_pkg::sat_count(req_data.mgmt_count);
      req_sat.deauth_count       = tats_pkg::sat_count(req_data.deauth_count);
      req_sat.bcast_deauth_count = tats_pkg::sat_count(req_data.bcast_deauth_count);
      req_sat.probe_count        = tats_pkg::sat_count(req_data.probe_count);
      req_sat.beacon_count       = tats_pkg::sat_count(req_data.beacon_count);
      req_sat.auth_count         = tats_pkg::sat_count(req_data.auth_count);

      case (win_ff)
         tats_pkg::WIN_MGMT:   x_cur = req_ff.mgmt_count;
         tats_pkg::WIN_DEAUTH: x_cur = req_ff.deauth_count;
         default:              x_cur = req_ff.probe_count;
      endcase
      fill_cur = fill_ff[win_ff];
      mean_cur = mean_ff[win_ff];
      rd_sel   = rd_data[win_ff];
      issue    = (idx_ff < fill_cur);

      dvar  = {1'b0, rd_sel, 8'b0} - {1'b0, mean_cur};
      adev  = dvar[MEAN_W] ? (~dvar[MEAN_W-1:0] + MEAN_W'(1)) : dvar[MEAN_W-1:0];
      xs    = {x_cur, 8'b0};
      zdiff = xs - mean_cur;
      root  = du_res[SD_W-1:0];
      lhs   = {{(SD_W-15){1'b0}}, x_cur, 16'b0};
      rhs   = {{(CNT_W+SD_W+1-32){1'b0}}, mean_cur, 8'b0} + {1'b0, prod_ff};
      zd    = z_ff - {8'b0, bm_ff};
      zp    = zd * tats_pkg::z_gain(win_ff);
      zt    = (zp[29:8] > {16'b0, tats_pkg::z_cap(win_ff)})
              ? tats_pkg::z_cap(win_ff) : zp[13:8];

      pushm = cal_ff ? 3'b111 : ~anom_ff;
      for (int i = 0; i < 3; i++) begin
         fill_nx[i] = (pushm[i] && (fill_ff[i] < FILL_W'(BASE_DEPTH)))
                      ? fill_ff[i] + FILL_W'(1) : fill_ff[i];
      end

      mg_s8 = {2'b0, req_ff.mgmt_count};
      pr_s8 = {2'b0, req_ff.probe_count};
      mm4   = {mean_ff[0], 2'b0};
      pm4   = {mean_ff[2], 2'b0};
      mm5   = {1'b0, mean_ff[0], 2'b0} + {3'b0, mean_ff[0]};
      limit = dthr_ff * smul_ff;
      excess = {{(25-TOT_W){1'b0}}, total_ff} - {1'b0, limit};

      sat = (acc_ff > ACC_W'(100)) ? 7'd100 : acc_ff[6:0];
      if (cal_ff) begin
         stat_code = tats_pkg::STATUS_CALIB;
      end else if (sat > 7'd70) begin
         stat_code = tats_pkg::STATUS_ATTACK;
      end else if (sat > 7'd30) begin
         stat_code = tats_pkg::STATUS_WARN;
      end else begin
         stat_code = tats_pkg::STATUS_SAFE;
      end
   end

   always_comb begin
      pkt_thr_in = pkt_thr_ff;
      bm_in      = bm_ff;
      dthr_in    = dthr_ff;
      smul_in    = smul_ff;
      bthr_in    = bthr_ff;
      pthr_in    = pthr_ff;
      if (csr_we) begin
         case (csr_index)
            tats_pkg::REG_PACKET_THR: pkt_thr_in = csr_wdata;
            tats_pkg::REG_BURST_MUL:  bm_in      = csr_wdata;
            tats_pkg::REG_DEAUTH_THR: dthr_in    = csr_wdata;
            tats_pkg::REG_STORM_MUL:  smul_in    = csr_wdata[7:0];
            tats_pkg::REG_BEACON_THR: bthr_in    = csr_wdata;
            tats_pkg::REG_PROBE_THR:  pthr_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      score_in     = score_ff;
      cal_in       = cal_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      p1_in        = 1'b0;
      p2_in        = 1'b0;
      sum_in       = sum_ff;
      qsum_in      = qsum_ff;
      sq_in        = sq_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      prod_in      = prod_ff;
      z_in         = z_ff;
      anom_in      = anom_ff;
      storm_in     = storm_ff;
      sptr_in      = sptr_ff;
      sidx_in      = sidx_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 3'b000;
      du_cmd       = '0;
      du_op        = '0;
      du_dvs       = '0;
      req_ready    = (state_ff == tats_pkg::ST_IDLE);

      case (state_ff)
         tats_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_sat;
               acc_in = (score_ff > 7'd15) ? ACC_W'(score_ff - 7'd15) : '0;
               if (req_data.scanning) begin
                  state_in = tats_pkg::ST_OUT;
               end else if (cal_ff) begin
                  state_in = tats_pkg::ST_PUSH;
               end else begin
                  if (req_sat.packet_count > pkt_thr_ff) begin
                     acc_in = ((score_ff > 7'd15) ? ACC_W'(score_ff - 7'd15) : '0)
                              + ACC_W'(20);
                  end
                  win_in   = tats_pkg::WIN_MGMT;
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = tats_pkg::ST_SUM;
               end
            end
         end
         tats_pkg::ST_SUM: begin
            if (fill_cur == '0) begin
               mean_in[win_ff] = '0;
               sd_in           = tats_pkg::win_floor(win_ff);
               state_in        = tats_pkg::ST_ANOM;
            end else begin
               if (issue) begin
                  idx_in = idx_ff + FILL_W'(1);
                  p1_in  = 1'b1;
               end
               if (p1_ff) begin
                  sum_in = sum_ff + SUM_W'(rd_sel);
               end
               if (!issue && !p1_ff) begin
                  du_cmd   = '{start: 1'b1, is_sqrt: 1'b0, is_long: 1'b0};
                  du_op    = OP_W'({sum_ff, 8'b0});
                  du_dvs   = tats_pkg::DVS_W'(fill_cur);
                  state_in = tats_pkg::ST_MEAN;
               end
            end
         end
         tats_pkg::ST_MEAN: begin
            if (du_stat.done) begin
               mean_in[win_ff] = du_res[MEAN_W-1:0];
               idx_in          = '0;
               qsum_in         = '0;
               state_in        = tats_pkg::ST_VAR;
            end
         end
         tats_pkg::ST_VAR: begin
            if (issue) begin
               idx_in = idx_ff + FILL_W'(1);
               p1_in  = 1'b1;
            end
            if (p1_ff) begin
               sq_in = adev * adev;
               p2_in = 1'b1;
            end
            if (p2_ff) begin
               qsum_in = qsum_ff + QS_W'(sq_ff);
            end
            if (!issue && !p1_ff && !p2_ff) begin
               du_cmd   = '{start: 1'b1, is_sqrt: 1'b0, is_long: 1'b1};
               du_op    = OP_W'(qsum_ff);
               du_dvs   = tats_pkg::DVS_W'(fill_cur);
               state_in = tats_pkg::ST_VDIV;
            end
         end
         tats_pkg::ST_VDIV: begin
            if (du_stat.done) begin
               du_cmd   = '{start: 1'b1, is_sqrt: 1'b1, is_long: 1'b1};
               du_op    = du_res;
               state_in = tats_pkg::ST_SQRT;
            end
         end
         tats_pkg::ST_SQRT: begin
            if (du_stat.done) begin
               sd_in    = (root < tats_pkg::win_floor(win_ff))
                          ? tats_pkg::win_floor(win_ff) : root;
               state_in = tats_pkg::ST_ANOM;
            end
         end
         tats_pkg::ST_ANOM: begin
            prod_in  = bm_ff * sd_ff;
            state_in = tats_pkg::ST_ACMP;
         end
         tats_pkg::ST_ACMP: begin
            anom_in[win_ff] = (fill_cur >= FILL_W'(5)) && (lhs > rhs);
            if (xs > mean_cur) begin
               du_cmd   = '{start: 1'b1, is_sqrt: 1'b0, is_long: 1'b0};
               du_op    = OP_W'({zdiff, 8'b0});
               du_dvs   = sd_ff;
               state_in = tats_pkg::ST_ZDIV;
            end else begin
               z_in     = '0;
               state_in = tats_pkg::ST_ZTERM;
            end
         end
         tats_pkg::ST_ZDIV: begin
            if (du_stat.done) begin
               z_in     = du_res[23:0];
               state_in = tats_pkg::ST_ZTERM;
            end
         end
         tats_pkg::ST_ZTERM: begin
            if ((z_ff > {8'b0, bm_ff}) &&
                ((win_ff != tats_pkg::WIN_PROBE) || (req_ff.probe_count > 16'd30))) begin
               acc_in = acc_ff + ACC_W'(zt);
            end
            if (win_ff == tats_pkg::WIN_PROBE) begin
               state_in = tats_pkg::ST_PUSH;
            end else begin
               win_in   = win_ff + 2'd1;
               idx_in   = '0;
               sum_in   = '0;
               state_in = tats_pkg::ST_SUM;
            end
         end
         tats_pkg::ST_PUSH: begin
            wr_en = pushm;
            for (int i = 0; i < 3; i++) begin
               fill_in[i] = fill_nx[i];
               if (pushm[i]) begin
                  ptr_in[i] = (ptr_ff[i] == AW'(BASE_DEPTH - 1)) ? '0
                              : ptr_ff[i] + AW'(1);
               end
            end
            if (cal_ff) begin
               // leave calibration once every baseline is full
               if ((fill_nx[0] >= FILL_W'(BASE_DEPTH)) &&
                   (fill_nx[1] >= FILL_W'(BASE_DEPTH)) &&
                   (fill_nx[2] >= FILL_W'(BASE_DEPTH))) begin
                  cal_in = 1'b0;
               end
               state_in = tats_pkg::ST_OUT;
            end else begin
               state_in = tats_pkg::ST_HEUR;
            end
         end
         tats_pkg::ST_HEUR: begin
            acc_in = acc_ff;
            if (req_ff.bcast_deauth_count >= 16'd3) begin
               acc_in = acc_in + ACC_W'(50);
            end else begin
               acc_in = acc_in + ACC_W'(req_ff.bcast_deauth_count[1:0]) * ACC_W'(20);
            end
            if (({mg_s8, 8'b0} > mm4) && (req_ff.mgmt_count > 16'd120) &&
                (req_ff.probe_count < 16'd20)) begin
               acc_in = acc_in + ACC_W'(25);
            end
            if (({pr_s8, 8'b0} > pm4) && (req_ff.probe_count > pthr_ff)) begin
               acc_in = acc_in + ACC_W'(30);
            end
            if (({1'b0, mg_s8, 8'b0} > mm5) && (req_ff.mgmt_count > 16'd150)) begin
               acc_in = acc_in + ACC_W'(35);
            end
            if ((fill_ff[1] < FILL_W'(5)) && (req_ff.deauth_count > dthr_ff)) begin
               acc_in = acc_in + ACC_W'(40);
            end
            if (req_ff.beacon_count > bthr_ff) begin
               acc_in = acc_in + ACC_W'(30);
            end
            if (req_ff.auth_count > 16'd50) begin
               acc_in = acc_in + ACC_W'(50);
            end
            storm_in[sptr_ff] = req_ff.deauth_count;
            sptr_in  = (sptr_ff == SP_W'(STORM_DEPTH - 1)) ? '0 : sptr_ff + SP_W'(1);
            sidx_in  = '0;
            total_in = '0;
            state_in = tats_pkg::ST_STORM;
         end
         tats_pkg::ST_STORM: begin
            if (sidx_ff == SI_W'(STORM_DEPTH)) begin
               state_in = tats_pkg::ST_SCMP;
            end else begin
               total_in = total_ff + TOT_W'(storm_ff[sidx_ff[SP_W-1:0]]);
               sidx_in  = sidx_ff + SI_W'(1);
            end
         end
         tats_pkg::ST_SCMP: begin
            if ({{(24-TOT_W){1'b0}}, total_ff} > limit) begin
               acc_in = (excess > 25'd15) ? acc_ff + ACC_W'(80)
                        : acc_ff + ACC_W'(50) + ACC_W'({excess[3:0], 1'b0});
            end
            state_in = tats_pkg::ST_OUT;
         end
         tats_pkg::ST_OUT: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               score_in            = sat;
               rsp_in.threat_score = sat;
               rsp_in.status       = stat_code;
               rsp_valid_in        = 1'b1;
               state_in            = tats_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tats_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tats_pkg::ST_IDLE;
         cal_ff       <= 1'b1;
         score_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         sptr_ff      <= '0;
         pkt_thr_ff   <= 16'd500;
         bm_ff        <= 16'd768;
         dthr_ff      <= 16'd10;
         smul_ff      <= 8'd3;
         bthr_ff      <= 16'd200;
         pthr_ff      <= 16'd50;
         for (int i = 0; i < 3; i++) begin
            fill_ff[i] <= '0;
            ptr_ff[i]  <= '0;
         end
         for (int i = 0; i < STORM_DEPTH; i++) begin
            storm_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         score_ff     <= score_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         sptr_ff      <= sptr_in;
         pkt_thr_ff   <= pkt_thr_in;
         bm_ff        <= bm_in;
         dthr_ff      <= dthr_in;
         smul_ff      <= smul_in;
         bthr_ff      <= bthr_in;
         pthr_ff      <= pthr_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         storm_ff     <= storm_in;
      end
      win_ff   <= win_in;
      req_ff   <= req_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      qsum_ff  <= qsum_in;
      sq_ff    <= sq_in;
      mean_ff  <= mean_in;
      sd_ff    <= sd_in;
      prod_ff  <= prod_in;
      z_ff     <= z_in;
      anom_ff  <= anom_in;
      sidx_ff  <= sidx_in;
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TATS_ASSERT_HOLDS(a_score_range, clock, reset, score_ff <= 7'd100, "score above 100")
   `TATS_ASSERT_IMPLIES(a_du_owner, clock, reset, du_stat.done,
      (state_ff == tats_pkg::ST_MEAN) || (state_ff == tats_pkg::ST_VDIV) ||
      (state_ff == tats_pkg::ST_SQRT) || (state_ff == tats_pkg::ST_ZDIV),
      "shared unit finished outside a waiting state")
   `TATS_ASSERT_IMPLIES(a_cal_fills, clock, reset, cal_ff,
      (fill_ff[0] == fill_ff[1]) && (fill_ff[1] == fill_ff[2]),
      "baselines out of step during calibration")
   `TATS_ASSERT_HOLDS(a_fill_max, clock, reset,
      (fill_ff[0] <= FILL_W'(BASE_DEPTH)) && (fill_ff[1] <= FILL_W'(BASE_DEPTH)) &&
      (fill_ff[2] <= FILL_W'(BASE_DEPTH)), "baseline fill beyond depth")

endmodule

`default_nettype wire
